// ===== design/kss_pkg.sv =====
// Package for the keyed sample store: transaction types, function and status codes.
// No dependencies.
package kss_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int HIST_DEPTH = 256;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int HIST_W = $clog2(HIST_DEPTH);
  localparam logic [31:0] ID_MAX_OBD = 32'd255;
  localparam logic [31:0] ID_MAX_UDS = 32'd65535;

  typedef enum logic [2:0] {
    FN_REGISTER = 3'd0,
    FN_RECORD   = 3'd1,
    FN_SET_FAV  = 3'd2,
    FN_GET_FAV  = 3'd3,
    FN_LATEST   = 3'd4,
    FN_HISTORY  = 3'd5,
    FN_CLEAR    = 3'd6,
    FN_UNUSED   = 3'd7
  } func_t;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_INVALID    = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_DUP_KEY    = 3'd3;
  localparam logic [2:0] ST_DUP_STABLE = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND  = 3'd5;
  localparam logic [2:0] ST_MISMATCH   = 3'd6;
  localparam logic [2:0] ST_NO_DATA    = 3'd7;

  localparam logic [1:0] PROTO_OBD = 2'd0;
  localparam logic [1:0] PROTO_UDS = 2'd1;

  typedef struct packed {
    logic [2:0]  func;
    logic [1:0]  protocol;
    logic [15:0] module_req;
    logic [31:0] identifier;
    logic [15:0] def_handle;
    logic [31:0] stable_id;
    logic        def_valid;
    logic        available;
    logic [63:0] sample_value;
    logic [63:0] timestamp;
    logic        flag;
    logic [7:0]  history_pos;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_handle;
    logic        out_available;
    logic [63:0] out_value;
    logic [63:0] out_time;
    logic        out_favourite;
    logic [8:0]  held_history;
    logic [63:0] total_samples;
    logic [6:0]  used_slots;
  } out_item_t;

  // classified command handed from front to back
  typedef struct packed {
    in_item_t    item;
    logic        key_ok;
    logic        bad_value;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_READ,
    BK_DONE,
    BK_CLEAR
  } bk_state_t;

endpackage

// ===== design/kss_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module kss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/kss_front.sv =====
// Front end: accepts input transactions, checks key validity and value finiteness,
// and queues classified commands (two-entry queue). Uses kss_pkg.
module kss_front
  import kss_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_push,
  output logic     in_full,
  input  in_item_t in_item,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd
);
  cmd_t     q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic     rd_r, rd_nxt;
  cmd_t     c;
  logic     push_ok, pop_ok;

  always_comb begin
    c.item = in_item;
    unique case (in_item.protocol)
      PROTO_OBD: c.key_ok = (in_item.module_req == 16'd0) && (in_item.identifier <= ID_MAX_OBD);
      PROTO_UDS: c.key_ok = (in_item.identifier <= ID_MAX_UDS);
      default:   c.key_ok = 1'b0;
    endcase
    c.bad_value = in_item.available && (in_item.sample_value[62:52] == 11'h7FF);
  end

  assign in_full   = (cnt_r == 2'd2);
  assign push_ok   = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop_ok    = cmd_take && cmd_valid;
  assign cmd       = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
    rd_nxt  = pop_ok ? ~rd_r : rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
    if (push_ok) q_r[rd_r ^ cnt_r[0]] <= c;
  end
endmodule

// ===== design/kss_back.sv =====
// Back end: key table search, slot and history memories, result register.
// Uses kss_pkg and kss_ram.
module kss_back
  import kss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  cmd_t      cmd,
  output logic      out_empty,
  input  logic      out_pop,
  output out_item_t out_item
);
  // key and stable id tables kept in flops for the parallel compare
  logic [49:0] key_r [NUM_SLOTS];
  logic [31:0] sid_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] fav_r, has_r;
  logic [SLOT_W:0] used_r, used_nxt;
  logic [HIST_W-1:0] head_r, head_nxt;
  logic [HIST_W:0] fill_r, fill_nxt;
  logic [63:0] total_r, total_nxt;
  bk_state_t st_r, st_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic hit_r, hit_nxt, sdup_r, sdup_nxt;
  out_item_t res_r, res_nxt;
  logic full_r, full_nxt;

  logic [49:0] key_in;
  logic [NUM_SLOTS-1:0] khit, shit;
  logic [SLOT_W-1:0] kidx;
  logic ram_we_slot, ram_we_hist;
  logic [SLOT_W-1:0] slot_waddr;
  logic [144:0] slot_wdata, slot_rdata;   // handle, avail, value, time
  logic [HIST_W-1:0] hist_waddr, hist_raddr;
  logic [144:0] hist_wdata, hist_rdata;
  logic reg_we, fav_we, has_set, clr;
  in_item_t it;

  assign it = cmd.item;
  assign key_in = {it.protocol, it.module_req, it.identifier};

  always_comb begin
    kidx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      khit[i] = (i < used_r) && (key_r[i] == key_in);
      shit[i] = (i < used_r) && (sid_r[i] == it.stable_id);
    end
    for (int i = NUM_SLOTS - 1; i >= 0; i--)
      if (khit[i]) kidx = SLOT_W'(i);
  end

  kss_ram #(.WIDTH(145), .DEPTH(NUM_SLOTS)) u_slot (
    .clk(clk), .we(ram_we_slot), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(idx_r), .rdata(slot_rdata)
  );
  kss_ram #(.WIDTH(145), .DEPTH(HIST_DEPTH)) u_hist (
    .clk(clk), .we(ram_we_hist), .waddr(hist_waddr), .wdata(hist_wdata),
    .raddr(hist_raddr), .rdata(hist_rdata)
  );

  assign out_empty = !full_r;
  assign out_item  = res_r;
  assign hist_raddr = head_r + it.history_pos[HIST_W-1:0];
  assign hist_wdata = {it.def_handle, it.available, it.sample_value, it.timestamp};

  always_comb begin
    st_nxt = st_r; idx_nxt = idx_r; hit_nxt = hit_r; sdup_nxt = sdup_r;
    res_nxt = res_r; full_nxt = full_r;
    used_nxt = used_r; head_nxt = head_r; fill_nxt = fill_r; total_nxt = total_r;
    cmd_take = 1'b0; ram_we_slot = 1'b0; ram_we_hist = 1'b0;
    slot_waddr = idx_r; slot_wdata = {it.def_handle, it.available, it.sample_value,
                                      it.timestamp};
    hist_waddr = head_r;
    reg_we = 1'b0; fav_we = 1'b0; has_set = 1'b0; clr = 1'b0;
    if (full_r && out_pop) full_nxt = 1'b0;
    unique case (st_r)
      BK_IDLE: if (cmd_valid && (!full_r || out_pop)) st_nxt = BK_SCAN;
      BK_SCAN: begin
        hit_nxt = |khit; sdup_nxt = |shit; idx_nxt = kidx;
        st_nxt = BK_READ;
      end
      BK_READ: st_nxt = BK_DONE;  // slot RAM read settles
      BK_DONE: begin
        res_nxt = '0;
        res_nxt.status = ST_OK;
        cmd_take = 1'b1;
        full_nxt = 1'b1;
        st_nxt = BK_IDLE;
        unique case (func_t'(it.func))
          FN_REGISTER: begin
            if (!it.def_valid || !cmd.key_ok) res_nxt.status = ST_INVALID;
            else if (hit_r) res_nxt.status = ST_DUP_KEY;
            else if (sdup_r) res_nxt.status = ST_DUP_STABLE;
            else if (used_r >= (SLOT_W+1)'(NUM_SLOTS)) res_nxt.status = ST_FULL;
            else begin
              reg_we = 1'b1;
              ram_we_slot = 1'b1;
              slot_waddr = used_r[SLOT_W-1:0];
              used_nxt = used_r + 1'b1;
            end
          end
          FN_RECORD: begin
            if (!it.def_valid || !cmd.key_ok || cmd.bad_value) res_nxt.status = ST_INVALID;
            else if (!hit_r) res_nxt.status = ST_NOT_FOUND;
            else if (slot_rdata[144:129] != it.def_handle) res_nxt.status = ST_MISMATCH;
            else begin
              has_set = 1'b1;
              ram_we_slot = 1'b1;
              ram_we_hist = 1'b1;
              if (fill_r < (HIST_W+1)'(HIST_DEPTH)) begin
                hist_waddr = head_r + fill_r[HIST_W-1:0];
                fill_nxt = fill_r + 1'b1;
              end else begin
                hist_waddr = head_r;
                head_nxt = head_r + 1'b1;
              end
              if (total_r != '1) total_nxt = total_r + 64'd1;
            end
          end
          FN_SET_FAV, FN_GET_FAV, FN_LATEST: begin
            if (!cmd.key_ok) res_nxt.status = ST_INVALID;
            else if (!hit_r) res_nxt.status = ST_NOT_FOUND;
            else if (func_t'(it.func) == FN_SET_FAV) fav_we = 1'b1;
            else if (func_t'(it.func) == FN_GET_FAV) res_nxt.out_favourite = fav_r[idx_r];
            else if (!has_r[idx_r]) res_nxt.status = ST_NO_DATA;
            else begin
              res_nxt.out_handle = slot_rdata[144:129];
              res_nxt.out_available = slot_rdata[128];
              res_nxt.out_value = slot_rdata[127:64];
              res_nxt.out_time = slot_rdata[63:0];
            end
          end
          FN_HISTORY: begin
            if ({1'b0, it.history_pos} >= fill_r) res_nxt.status = ST_NO_DATA;
            else begin
              res_nxt.out_handle = hist_rdata[144:129];
              res_nxt.out_available = hist_rdata[128];
              res_nxt.out_value = hist_rdata[127:64];
              res_nxt.out_time = hist_rdata[63:0];
            end
          end
          FN_CLEAR: begin
            clr = 1'b1; head_nxt = '0; fill_nxt = '0; total_nxt = '0;
          end
          default: res_nxt.status = ST_INVALID;
        endcase
        res_nxt.held_history = 9'(fill_nxt);
        res_nxt.total_samples = total_nxt;
        res_nxt.used_slots = 7'(used_nxt);
      end
      default: st_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE; full_r <= 1'b0; used_r <= '0; head_r <= '0;
      fill_r <= '0; total_r <= '0; fav_r <= '0; has_r <= '0;
    end else begin
      st_r <= st_nxt; full_r <= full_nxt; used_r <= used_nxt; head_r <= head_nxt;
      fill_r <= fill_nxt; total_r <= total_nxt;
      if (reg_we) begin
        fav_r[used_r[SLOT_W-1:0]] <= 1'b0;
        has_r[used_r[SLOT_W-1:0]] <= 1'b0;
      end
      if (fav_we) fav_r[idx_r] <= it.flag;
      if (has_set) has_r[idx_r] <= 1'b1;
      if (clr) has_r <= '0;
    end
    idx_r <= idx_nxt; hit_r <= hit_nxt; sdup_r <= sdup_nxt; res_r <= res_nxt;
    if (reg_we) begin
      key_r[used_r[SLOT_W-1:0]] <= key_in;
      sid_r[used_r[SLOT_W-1:0]] <= it.stable_id;
    end
  end
endmodule

// ===== design/keyed_sample_store_with_history.sv =====
// Top level of the keyed sample store: front classifier, back executor.
// Uses kss_pkg, kss_front, kss_back.
//   channel  direction  handshake         payload
//   in_      in         in_push/in_full   in_item_t
//   out_     out        out_pop/out_empty out_item_t
// Each transaction passes through the back-end states scan, slot RAM read and execute,
// plus the idle hand-off; the read state waits for the registered slot and history RAM reads.
// Reset is synchronous and needs no clearing pass.
// The front queue holds two transactions while the result register waits for out_pop.
module keyed_sample_store_with_history
  import kss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_push,
  output logic      in_full,
  input  in_item_t  in_item,
  input  logic      out_pop,
  output logic      out_empty,
  output out_item_t out_item
);
  logic cmd_valid, cmd_take;
  cmd_t cmd;

  kss_front u_front (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_item(in_item),
    .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd)
  );
  kss_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_take(cmd_take), .cmd(cmd),
    .out_empty(out_empty), .out_pop(out_pop), .out_item(out_item)
  );

  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid) else $error("command taken from empty queue");
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_item.used_slots <= 7'd64 || out_empty) else $error("slot count overflow");
  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |=> !out_empty) else $error("result lost");
endmodule
